@@ hdl/fcc_pkg.sv @@
// Shared constants and types for the frame CRC-16 checker.
// No dependencies; used by fcc_crc_byte and frame_crc16_checker_top.
`default_nettype none
package fcc_pkg;

	// Frame layout: payload bytes followed by a two-byte big-endian CRC.
	localparam int FRAME_BYTES = 10;
	localparam int PAYLOAD_BYTES = FRAME_BYTES - 2;
	localparam int POS_W = $clog2(FRAME_BYTES + 1);

	// Saturating frame counters; the result port carries the low 32 bits.
	localparam int COUNT_WIDTH = 32;
	localparam int TOTAL_W = 32;

	// CRC-16-CCITT, XMODEM flavor: MSB first, no reflection, no final XOR.
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'h0000;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;

	typedef enum logic [1:0] {
		VERDICT_MATCH    = 2'd0,
		VERDICT_MISMATCH = 2'd1,
		VERDICT_SKIP     = 2'd2
	} verdict_t;

endpackage
`default_nettype wire

@@ hdl/fcc_crc_byte.sv @@
// Byte-wide CRC-16-CCITT update: one XOR network, eight bit steps unrolled.
// Depends on fcc_pkg for the polynomial.
`default_nettype none
module fcc_crc_byte (
	input  wire logic [15:0] crc_in,
	input  wire logic [7:0]  data,
	output logic      [15:0] crc_out
);

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ fcc_pkg::CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule
`default_nettype wire

@@ hdl/frame_crc16_checker_top.sv @@
// Top level of the frame CRC-16 checker: frame state, counters, result register.
// Depends on fcc_pkg and fcc_crc_byte.
//
// Usage:
//   Slave side (s_*) takes one frame byte per transaction; s_tlast marks the
//   last byte of a frame. Bytes without s_tlast produce no result.
//   Master side (m_*) delivers one result transaction per frame: verdict in
//   m_tuser, computed and received CRCs and three saturating frame counters
//   in m_tdata.
//   Output: the result for a frame appears on m_tvalid in the cycle after its
//   last byte is accepted.
//   Throughput: one byte per cycle while the output register is empty or
//   m_tready is high; the byte-wide CRC update is a single XOR network
//   between the frame state and the result register.
//   Stall: while a result waits in the output register and m_tready is low,
//   no byte is accepted; the next is taken in the same cycle the register drains.
//   Reset (arst_n low, asynchronous): CRC, byte position, tail bytes and all
//   counters clear to zero, and the output register empties.
//   A frame whose length is not FRAME_BYTES gets the skip verdict.
`default_nettype none
module frame_crc16_checker_top (
	input  wire logic         clk,
	input  wire logic         arst_n,

	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // [7:0] data_byte
	input  wire logic         s_tlast,   // frame_end

	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [127:0] m_tdata,   // [15:0] computed_crc, [31:16] received_crc,
	                                     // [63:32] match_total, [95:64] mismatch_total,
	                                     // [127:96] skip_total
	output logic      [1:0]   m_tuser    // [1:0] verdict
);

	fcc_pkg::pos_t     pos_q;
	logic [15:0]       crc_q;
	logic [15:0]       tail_q;
	fcc_pkg::count_t   good_q, bad_q, drop_q;

	logic              m_valid_q;
	fcc_pkg::verdict_t verdict_q;
	logic [15:0]       out_crc_q, out_tail_q;
	logic [fcc_pkg::TOTAL_W-1:0] out_good_q, out_bad_q, out_drop_q;

	logic              accept;
	logic [15:0]       crc_upd, crc_next, tail_next;
	logic              in_payload, len_ok;
	fcc_pkg::verdict_t verdict_next;
	fcc_pkg::count_t   good_next, bad_next, drop_next;

	fcc_crc_byte u_crc (
		.crc_in  (crc_q),
		.data    (s_tdata),
		.crc_out (crc_upd)
	);

	assign s_tready = !m_valid_q || m_tready;
	assign accept = s_tvalid && s_tready;

	assign in_payload = pos_q < fcc_pkg::POS_W'(fcc_pkg::PAYLOAD_BYTES);
	assign len_ok     = pos_q == fcc_pkg::POS_W'(fcc_pkg::FRAME_BYTES - 1);
	assign crc_next   = in_payload ? crc_upd : crc_q;
	assign tail_next  = {tail_q[7:0], s_tdata};

	always_comb begin
		good_next = good_q;
		bad_next  = bad_q;
		drop_next = drop_q;
		if (!len_ok) begin
			verdict_next = fcc_pkg::VERDICT_SKIP;
			if (drop_q != '1) drop_next = drop_q + 1'b1;
		end else if (crc_next == tail_next) begin
			verdict_next = fcc_pkg::VERDICT_MATCH;
			if (good_q != '1) good_next = good_q + 1'b1;
		end else begin
			verdict_next = fcc_pkg::VERDICT_MISMATCH;
			if (bad_q != '1) bad_next = bad_q + 1'b1;
		end
	end

	// Frame state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			crc_q  <= fcc_pkg::CRC_INIT;
			tail_q <= '0;
			good_q <= '0;
			bad_q  <= '0;
			drop_q <= '0;
		end else if (accept) begin
			tail_q <= tail_next;
			if (s_tlast) begin
				// restart the frame
				pos_q  <= '0;
				crc_q  <= fcc_pkg::CRC_INIT;
				good_q <= good_next;
				bad_q  <= bad_next;
				drop_q <= drop_next;
			end else begin
				crc_q <= crc_next;
				if (pos_q < fcc_pkg::POS_W'(fcc_pkg::FRAME_BYTES)) pos_q <= pos_q + 1'b1;
			end
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept && s_tlast) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Output payload: load on the last byte of a frame
	always_ff @(posedge clk) begin
		if (accept && s_tlast) begin
			verdict_q  <= verdict_next;
			out_crc_q  <= crc_next;
			out_tail_q <= tail_next;
			out_good_q <= fcc_pkg::TOTAL_W'(good_next);
			out_bad_q  <= fcc_pkg::TOTAL_W'(bad_next);
			out_drop_q <= fcc_pkg::TOTAL_W'(drop_next);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = verdict_q;
	assign m_tdata  = {out_drop_q, out_bad_q, out_good_q, out_tail_q, out_crc_q};

endmodule
`default_nettype wire
